// ===== rtl/tsc_pkg.sv =====
package tsc_pkg;

  // Store geometry
  localparam int unsigned DEPTH_SETS  = 16384;
  localparam int unsigned SET_W       = $clog2(DEPTH_SETS);
  localparam int unsigned NCH         = 4;
  localparam int unsigned RAW_W       = 24;
  localparam int unsigned OUT_W       = 24;
  localparam int unsigned IDX_W       = 14;

  // Sample word handling
  localparam int unsigned SAMPLE_BITS = 24;
  localparam logic [31:0] SAMPLE_MASK = 32'hFFFF_FFFF >> (32 - SAMPLE_BITS);

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_POST_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOPE      = 3'd4;

  localparam logic [15:0] POST_COUNT_RST = 16'd128;
  localparam logic [15:0] LEVEL_RST      = 16'd10000;

  // Item kinds
  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_FRAME = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  // Trigger modes
  localparam logic [1:0] MODE_IMMEDIATE = 2'd0;
  localparam logic [1:0] MODE_LEVEL     = 2'd1;
  localparam logic [1:0] MODE_EXTERNAL  = 2'd2;
  localparam logic [1:0] MODE_NEVER     = 2'd3;

  typedef logic [NCH-1:0][OUT_W-1:0] sample_set_t;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } ctrl_state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic accept;   // input item taken this cycle
    logic load_rd;  // move read-back set into the output register
  } ctrl_cmd_t;

  // Mask a raw word to the sample width and sign-extend it to 32 bits
  function automatic logic [31:0] sample_ext(input logic [RAW_W-1:0] raw);
    logic [31:0] w;
    w = 32'(raw) & SAMPLE_MASK;
    if (w[SAMPLE_BITS-1]) begin
      w = w | ~SAMPLE_MASK;
    end
    return w;
  endfunction

endpackage

// ===== rtl/tsc_ctrl.sv =====
module tsc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic [1:0]         kind_i,
  input  logic               out_stall_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  output tsc_pkg::ctrl_cmd_t cmd_o
);
  import tsc_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        accept;
  logic        load_out;

  // Take an item only when not waiting on the store and the output slot frees up
  assign in_stall_o = (state_q == ST_READ) || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d       = state_q;
    cmd_o.accept  = 1'b0;
    cmd_o.load_rd = 1'b0;
    load_out      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.accept = 1'b1;
          if (kind_i == KIND_READ) begin
            state_d = ST_READ;
          end else begin
            load_out = 1'b1;
          end
        end
      end
      ST_READ: begin
        cmd_o.load_rd = 1'b1;
        load_out      = 1'b1;
        state_d       = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Output slot: filled on load, emptied when taken
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== rtl/tsc_datapath.sv =====
module tsc_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  tsc_pkg::ctrl_cmd_t                  cmd_i,
  input  logic                                cfg_we_i,
  input  logic [tsc_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [tsc_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic [1:0]                          kind_i,
  input  logic [tsc_pkg::RAW_W-1:0]           raw_chan0_i,
  input  logic [tsc_pkg::RAW_W-1:0]           raw_chan1_i,
  input  logic [tsc_pkg::RAW_W-1:0]           raw_chan2_i,
  input  logic [tsc_pkg::RAW_W-1:0]           raw_chan3_i,
  input  logic                                ext_event_n_i,
  input  logic [tsc_pkg::IDX_W-1:0]           set_index_i,
  output tsc_pkg::sample_set_t                values_o,
  output logic                                capturing_o,
  output logic                                triggered_o,
  output logic                                event_out_o,
  output logic                                has_wrapped_o
);
  import tsc_pkg::*;

  // Configuration registers
  logic [15:0] post_count_q;
  logic [1:0]  mode_q;
  logic [1:0]  channel_q;
  logic [15:0] level_q;
  logic        slope_q;

  // Capture state
  logic [SET_W-1:0] write_set_q, write_set_d;
  logic             wrap_q, wrap_d;
  logic             post_q, post_d;
  logic [15:0]      remaining_q, remaining_d;
  logic             active_q, active_d;
  logic             event_q, event_d;

  // Store and output registers
  sample_set_t mem_q [DEPTH_SETS];
  sample_set_t rd_data_q;
  sample_set_t out_val_q, out_val_d;
  logic        out_load;

  logic               wr_en;
  logic               rd_en;
  logic [SET_W-1:0]   rd_addr;
  logic [SET_W-1:0]   oldest;
  logic [SET_W:0]     next_set;
  logic [31:0]        ext_w [NCH];
  logic [31:0]        ext_sel;
  logic signed [32:0] s_cmp;
  logic signed [32:0] lv_cmp;
  logic               level_hit;
  sample_set_t        frame_set;

  // Unpack the raw words
  assign ext_w[0] = sample_ext(raw_chan0_i);
  assign ext_w[1] = sample_ext(raw_chan1_i);
  assign ext_w[2] = sample_ext(raw_chan2_i);
  assign ext_w[3] = sample_ext(raw_chan3_i);

  always_comb begin
    for (int ch = 0; ch < NCH; ch++) begin
      frame_set[ch] = ext_w[ch][OUT_W-1:0];
    end
  end

  // Level test on the chosen channel, signed sample against unsigned level
  assign ext_sel   = ext_w[channel_q];
  assign s_cmp     = {ext_sel[31], ext_sel};
  assign lv_cmp    = {17'd0, level_q};
  assign level_hit = slope_q ? (s_cmp >= lv_cmp) : (s_cmp <= lv_cmp);

  // Read address: offset from the oldest set, wraps with the store
  assign oldest   = wrap_q ? write_set_q : '0;
  assign rd_addr  = oldest + SET_W'(set_index_i);
  assign next_set = {1'b0, write_set_q} + 1'b1;

  // Item processing
  always_comb begin
    write_set_d = write_set_q;
    wrap_d      = wrap_q;
    post_d      = post_q;
    remaining_d = remaining_q;
    active_d    = active_q;
    event_d     = event_q;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    out_load    = 1'b0;
    out_val_d   = out_val_q;

    if (cmd_i.accept) begin
      case (kind_i)
        KIND_START: begin
          write_set_d = '0;
          wrap_d      = 1'b0;
          post_d      = 1'b0;
          event_d     = 1'b0;
          remaining_d = post_count_q;
          active_d    = (post_count_q != 16'd0);
          out_load    = 1'b1;
          out_val_d   = '0;
        end
        KIND_FRAME: begin
          out_load  = 1'b1;
          out_val_d = frame_set;
          if (active_q) begin
            wr_en = 1'b1;
            if (post_q) begin
              remaining_d = remaining_q - 16'd1;
            end else begin
              case (mode_q)
                MODE_IMMEDIATE: begin
                  post_d  = 1'b1;
                  event_d = 1'b1;
                end
                MODE_LEVEL: begin
                  if (level_hit) begin
                    post_d  = 1'b1;
                    event_d = 1'b1;
                  end
                end
                MODE_EXTERNAL: begin
                  if (!ext_event_n_i) begin
                    post_d = 1'b1;
                  end
                end
                default: begin
                end
              endcase
            end
            write_set_d = next_set[SET_W-1:0];
            if (next_set[SET_W]) begin
              wrap_d = 1'b1;
            end
            if (remaining_d == 16'd0) begin
              active_d = 1'b0;
            end
          end
        end
        KIND_READ: begin
          rd_en = 1'b1;
        end
        default: begin
          out_load  = 1'b1;
          out_val_d = '0;
        end
      endcase
    end

    if (cmd_i.load_rd) begin
      out_load  = 1'b1;
      out_val_d = rd_data_q;
    end
  end

  // Control and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      post_count_q <= POST_COUNT_RST;
      mode_q       <= MODE_IMMEDIATE;
      channel_q    <= 2'd0;
      level_q      <= LEVEL_RST;
      slope_q      <= 1'b1;
      write_set_q  <= '0;
      wrap_q       <= 1'b0;
      post_q       <= 1'b0;
      remaining_q  <= 16'd0;
      active_q     <= 1'b0;
      event_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_POST_COUNT: post_count_q <= cfg_data_i;
          CFG_MODE:       mode_q       <= cfg_data_i[1:0];
          CFG_CHANNEL:    channel_q    <= cfg_data_i[1:0];
          CFG_LEVEL:      level_q      <= cfg_data_i;
          CFG_SLOPE:      slope_q      <= cfg_data_i[0];
          default: begin
          end
        endcase
      end
      write_set_q <= write_set_d;
      wrap_q      <= wrap_d;
      post_q      <= post_d;
      remaining_q <= remaining_d;
      active_q    <= active_d;
      event_q     <= event_d;
    end
  end

  // Sample store, one set per row
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[write_set_q] <= frame_set;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  // Result values
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_val_q <= out_val_d;
    end
  end

  // Flags show the state left by the last item
  assign values_o      = out_val_q;
  assign capturing_o   = active_q;
  assign triggered_o   = post_q;
  assign event_out_o   = event_q;
  assign has_wrapped_o = wrap_q;

endmodule

// ===== rtl/triggered_sample_capture.sv =====
// Triggered sample capture with pretrigger history.
// Input channel (in_valid_i / in_stall_o) carries one item: kind_i selects
// start, sample frame or read-back; raw_chan*_i, ext_event_n_i and
// set_index_i travel with it. Output channel (out_valid_o / out_stall_i)
// returns exactly one result item per input item, in order.
// Start and frame items produce their result in the cycle after acceptance;
// a read item passes through the registered store read, then the output load.
// With the one-slot output register, starts and frames go at one item per
// cycle unless stalled; a read blocks new items until its result is loaded.
// While the receiver stalls, the result stays in the output register and a
// new item is taken in the same cycle the result is finally accepted.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_index_i
// (0 post count, 1 mode, 2 channel, 3 level, 4 slope); write only while idle.
// Reset (rst_ni low, asynchronous) disarms capture, clears trigger and wrap
// state and restores configuration defaults. The store contents are not
// cleared; no clearing pass is needed before the first item.
module triggered_sample_capture (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [tsc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [tsc_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [1:0]                      kind_i,
  input  logic [tsc_pkg::RAW_W-1:0]       raw_chan0_i,
  input  logic [tsc_pkg::RAW_W-1:0]       raw_chan1_i,
  input  logic [tsc_pkg::RAW_W-1:0]       raw_chan2_i,
  input  logic [tsc_pkg::RAW_W-1:0]       raw_chan3_i,
  input  logic                            ext_event_n_i,
  input  logic [tsc_pkg::IDX_W-1:0]       set_index_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [tsc_pkg::OUT_W-1:0] value0_o,
  output logic signed [tsc_pkg::OUT_W-1:0] value1_o,
  output logic signed [tsc_pkg::OUT_W-1:0] value2_o,
  output logic signed [tsc_pkg::OUT_W-1:0] value3_o,
  output logic                            capturing_o,
  output logic                            triggered_o,
  output logic                            event_out_o,
  output logic                            has_wrapped_o
);
  import tsc_pkg::*;

  ctrl_cmd_t   cmd;
  sample_set_t values;

  tsc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .kind_i      (kind_i),
    .out_stall_i (out_stall_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  tsc_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .kind_i        (kind_i),
    .raw_chan0_i   (raw_chan0_i),
    .raw_chan1_i   (raw_chan1_i),
    .raw_chan2_i   (raw_chan2_i),
    .raw_chan3_i   (raw_chan3_i),
    .ext_event_n_i (ext_event_n_i),
    .set_index_i   (set_index_i),
    .values_o      (values),
    .capturing_o   (capturing_o),
    .triggered_o   (triggered_o),
    .event_out_o   (event_out_o),
    .has_wrapped_o (has_wrapped_o)
  );

  assign value0_o = values[0];
  assign value1_o = values[1];
  assign value2_o = values[2];
  assign value3_o = values[3];

endmodule

// ===== rtl/tsc_checker.sv =====
module tsc_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input logic [1:0]                      kind_i,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic [tsc_pkg::OUT_W-1:0]       value0_o,
  input logic                            triggered_o,
  input logic                            event_out_o,
  input logic                            has_wrapped_o
);
  import tsc_pkg::*;

  // A stalled result item stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result item dropped while stalled");

  // A stalled result item keeps its channel 0 value
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(value0_o))
    else $error("result item changed while stalled");

  // Event line only ever follows a trigger
  a_event_trig: assert property (@(posedge clk_i) disable iff (!rst_ni)
    event_out_o |-> triggered_o)
    else $error("event line without trigger");

  // A start item clears trigger, event and wrap state
  a_start_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (kind_i == KIND_START)
      |=> !triggered_o && !event_out_o && !has_wrapped_o)
    else $error("start item left stale capture state");

  // Start and frame items produce a result in the next cycle
  a_fast_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (kind_i != KIND_READ) |=> out_valid_o)
    else $error("missing result after start or frame item");

endmodule

bind triggered_sample_capture tsc_checker u_tsc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .kind_i        (kind_i),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .value0_o      (value0_o),
  .triggered_o   (triggered_o),
  .event_out_o   (event_out_o),
  .has_wrapped_o (has_wrapped_o)
);
